/* rtl/assert_macros.svh */
// assertion macros shared by the monitor rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/qolm_pkg.sv */
// types and codes for the queue occupancy latency monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qolm_pkg;

    typedef enum logic [2:0] {
        ACT_ENQ       = 3'd0,
        ACT_DEQ       = 3'd1,
        ACT_EPOCH_CLR = 3'd2,
        ACT_RUN_TIME  = 3'd3,
        ACT_RUN_ENT   = 3'd4,
        ACT_EP_TIME   = 3'd5,
        ACT_EP_ENT    = 3'd6,
        ACT_NONE      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tag;
        logic [47:0] now;
        logic [6:0]  bin;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  queue_length;
        logic [6:0]  max_queue_length;
        logic [47:0] wait_time;
        logic [47:0] max_wait_time;
        logic [31:0] total_requests;
        logic [31:0] total_departures;
        logic [63:0] total_wait;
        logic [31:0] epoch_requests;
        logic [31:0] epoch_departures;
        logic [63:0] epoch_wait;
        logic [47:0] bin_value;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_EPOCH,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic write;
        logic epoch_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic epoch_done;
        logic is_epoch;
    } stat_t;

endpackage
`default_nettype wire

/* rtl/queue_occupancy_latency_monitor.sv */
// channel  | handshake            | payload
// in       | in_valid / in_ready  | in_item  (qolm_pkg::in_item_t)
// out      | out_valid/ out_ready | out_item (qolm_pkg::out_item_t)
// queue events and bin reads step through capture, memory read, update and result load
// an epoch reset sweeps all MAX_LENGTH+1 epoch bins before its result is loaded
// after reset a clearing pass over all MAX_LENGTH+1 bins runs before the first beat is taken
// a finished result waits in the output register while the next beat is captured
// depends on qolm_pkg, qolm_ctrl, qolm_datapath
`timescale 1ns / 1ps
`default_nettype none
module queue_occupancy_latency_monitor #(
    parameter int MAX_LENGTH = 64,
    parameter int TAG_COUNT  = 256,
    parameter int TIME_BITS  = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire qolm_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output qolm_pkg::out_item_t      out_item
);
    qolm_pkg::cmd_t  cmd;
    qolm_pkg::stat_t stat;

    qolm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    qolm_datapath #(
        .MAX_LENGTH (MAX_LENGTH),
        .TAG_COUNT  (TAG_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_item  (in_item),
        .out_item (out_item)
    );
endmodule
`default_nettype wire

/* rtl/qolm_datapath.sv */
// datapath: arrival memory, bin memories, counters and result register
// depends on qolm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module qolm_datapath #(
    parameter int MAX_LENGTH = 64,
    parameter int TAG_COUNT  = 256,
    parameter int TIME_BITS  = 48
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire qolm_pkg::cmd_t     cmd,
    output qolm_pkg::stat_t         stat,
    input  wire qolm_pkg::in_item_t in_item,
    output qolm_pkg::out_item_t     out_item
);
    localparam int BINS   = MAX_LENGTH + 1;
    localparam int BW     = $clog2(BINS);
    localparam int TW     = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int TAGM   = (TAG_COUNT < 256) ? TAG_COUNT : 256;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS-1:0] arr_mem [TAG_COUNT];
    logic [TIME_BITS-1:0] rbt_mem [BINS];
    logic [31:0]          rbe_mem [BINS];
    logic [TIME_BITS-1:0] ebt_mem [BINS];
    logic [31:0]          ebe_mem [BINS];
    logic [TAG_COUNT-1:0] present_reg;

    qolm_pkg::in_item_t   item_reg;
    logic [BW-1:0]        len_reg, peak_reg, sweep_reg;
    logic [TIME_BITS-1:0] last_reg, wpeak_reg;
    logic [31:0]          req_reg, dep_reg, ereq_reg, edep_reg;
    logic [63:0]          wsum_reg, ewsum_reg;
    logic [TIME_BITS-1:0] arr_q, rbt_q, ebt_q, wait_reg;
    logic [31:0]          rbe_q, ebe_q;
    qolm_pkg::out_item_t  out_reg;

    logic [TW-1:0]        tag_i;
    logic [TIME_BITS-1:0] now_i;
    logic [BW-1:0]        rd_addr, new_len, ent_addr;
    logic                 do_enq, do_deq, bin_ok;
    logic [TIME_BITS-1:0] dt, wt;

    function automatic logic [TIME_BITS-1:0] tsat(input logic [TIME_BITS-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    assign tag_i = TW'(32'(item_reg.tag) % TAGM);
    assign now_i = TIME_BITS'(item_reg.now);
    assign do_enq = (item_reg.action == qolm_pkg::ACT_ENQ) && (32'(len_reg) < MAX_LENGTH);
    assign do_deq = (item_reg.action == qolm_pkg::ACT_DEQ) && (len_reg != '0)
                    && present_reg[tag_i];
    assign bin_ok = 32'(item_reg.bin) <= MAX_LENGTH;
    assign new_len = do_enq ? len_reg + BW'(1) : len_reg - BW'(1);
    assign dt = (now_i >= last_reg) ? now_i - last_reg : '0;
    assign wt = (now_i >= arr_q) ? now_i - arr_q : '0;
    // read bin: old length for charging, requested bin for reads
    assign rd_addr = (item_reg.action == qolm_pkg::ACT_ENQ ||
                      item_reg.action == qolm_pkg::ACT_DEQ) ? len_reg
                     : (bin_ok ? BW'(item_reg.bin) : '0);
    // entry bins are bumped at the new length
    assign ent_addr = (do_enq || do_deq) ? new_len : rd_addr;

    assign stat.clear_done = (32'(sweep_reg) == MAX_LENGTH);
    assign stat.epoch_done = (32'(sweep_reg) == MAX_LENGTH);
    assign stat.is_epoch   = (in_item.action == qolm_pkg::ACT_EPOCH_CLR);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.read)
        begin
            arr_q <= arr_mem[tag_i];
            rbt_q <= rbt_mem[rd_addr];
            rbe_q <= rbe_mem[ent_addr];
            ebt_q <= ebt_mem[rd_addr];
            ebe_q <= ebe_mem[ent_addr];
        end
        if (cmd.clear_step || cmd.epoch_step)
        begin
            ebt_mem[sweep_reg] <= '0;
            ebe_mem[sweep_reg] <= '0;
        end
        if (cmd.clear_step)
        begin
            rbt_mem[sweep_reg] <= '0;
            rbe_mem[sweep_reg] <= '0;
        end
        if (cmd.write && do_enq)
        begin
            arr_mem[tag_i] <= now_i;
        end
        // charge old bin time, count one entry into the new bin
        if (cmd.write && (do_enq || do_deq))
        begin
            rbt_mem[len_reg] <= tsat(rbt_q, dt);
            ebt_mem[len_reg] <= tsat(ebt_q, dt);
            rbe_mem[new_len] <= inc32(rbe_q);
            ebe_mem[new_len] <= inc32(ebe_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            len_reg <= '0; peak_reg <= '0; sweep_reg <= '0;
            last_reg <= '0; wpeak_reg <= '0;
            req_reg <= '0; dep_reg <= '0; ereq_reg <= '0; edep_reg <= '0;
            wsum_reg <= '0; ewsum_reg <= '0; wait_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step || cmd.epoch_step)
            begin
                sweep_reg <= stat.clear_done ? '0 : sweep_reg + BW'(1);
            end
            if (cmd.epoch_step && sweep_reg == '0)
            begin
                ereq_reg <= '0; edep_reg <= '0; ewsum_reg <= '0;
            end
            if (cmd.capture)
            begin
                wait_reg <= '0;
            end
            if (cmd.write && (do_enq || do_deq))
            begin
                len_reg <= new_len;
                if (new_len > peak_reg)
                begin
                    peak_reg <= new_len;
                end
                last_reg <= now_i;
                if (do_enq)
                begin
                    present_reg[tag_i] <= 1'b1;
                    req_reg <= inc32(req_reg);
                    ereq_reg <= inc32(ereq_reg);
                end
                else
                begin
                    present_reg[tag_i] <= 1'b0;
                    wait_reg <= wt;
                    dep_reg <= inc32(dep_reg);
                    edep_reg <= inc32(edep_reg);
                    wsum_reg <= sat64(wsum_reg, 64'(wt));
                    ewsum_reg <= sat64(ewsum_reg, 64'(wt));
                    if (wt > wpeak_reg)
                    begin
                        wpeak_reg <= wt;
                    end
                end
            end
        end
    end

    // bin read result computed in the write cycle
    logic [TIME_BITS-1:0] bv, run_dt;
    always_comb
    begin
        run_dt = (rd_addr == len_reg) ? dt : '0;
        bv = '0;
        if (bin_ok)
        begin
            case (item_reg.action)
                qolm_pkg::ACT_RUN_TIME: bv = tsat(rbt_q, run_dt);
                qolm_pkg::ACT_RUN_ENT:  bv = TIME_BITS'(rbe_q);
                qolm_pkg::ACT_EP_TIME:  bv = tsat(ebt_q, run_dt);
                qolm_pkg::ACT_EP_ENT:   bv = TIME_BITS'(ebe_q);
                default:                bv = '0;
            endcase
        end
    end

    logic [TIME_BITS-1:0] bv_reg;
    logic [1:0]           st_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            bv_reg <= bv;
            st_reg <= qolm_pkg::ST_OK;
            if (item_reg.action == qolm_pkg::ACT_ENQ && !do_enq)
                st_reg <= qolm_pkg::ST_FULL;
            else if (item_reg.action == qolm_pkg::ACT_DEQ && len_reg == '0)
                st_reg <= qolm_pkg::ST_EMPTY;
            else if (item_reg.action == qolm_pkg::ACT_DEQ && !do_deq)
                st_reg <= qolm_pkg::ST_UNKNOWN;
        end
        if (cmd.epoch_step)
        begin
            bv_reg <= '0;
            st_reg <= qolm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.queue_length     <= 7'(len_reg);
            out_reg.max_queue_length <= 7'(peak_reg);
            out_reg.wait_time        <= 48'(wait_reg);
            out_reg.max_wait_time    <= 48'(wpeak_reg);
            out_reg.total_requests   <= req_reg;
            out_reg.total_departures <= dep_reg;
            out_reg.total_wait       <= wsum_reg;
            out_reg.epoch_requests   <= ereq_reg;
            out_reg.epoch_departures <= edep_reg;
            out_reg.epoch_wait       <= ewsum_reg;
            out_reg.bin_value        <= 48'(bv_reg);
            out_reg.status           <= st_reg;
        end
    end
    assign out_item = out_reg;

    `ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, 32'(len_reg) <= MAX_LENGTH)
    `ASSERT_IMPL(a_peak_ge_len, clk, rst_n, 1'b1, peak_reg >= len_reg)
    `ASSERT_NEXT(a_deq_clears_tag, clk, rst_n, cmd.write && do_deq, !present_reg[$past(tag_i)])
endmodule
`default_nettype wire

/* rtl/qolm_ctrl.sv */
// controller: clearing sweep, per-beat read/write sequence, result handshake
// depends on qolm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module qolm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire qolm_pkg::stat_t stat,
    output qolm_pkg::cmd_t       cmd
);
    qolm_pkg::state_t state_reg, state_next;
    logic valid_reg, valid_next;
    logic accept;

    // result register may hold a beat while the next one is worked on
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qolm_pkg::S_CLEAR: if (stat.clear_done) state_next = qolm_pkg::S_IDLE;
            qolm_pkg::S_IDLE:
                if (accept) state_next = stat.is_epoch ? qolm_pkg::S_EPOCH
                                                       : qolm_pkg::S_READ;
            qolm_pkg::S_READ:  state_next = qolm_pkg::S_WRITE;
            qolm_pkg::S_WRITE: state_next = qolm_pkg::S_OUT;
            qolm_pkg::S_EPOCH: if (stat.epoch_done) state_next = qolm_pkg::S_OUT;
            qolm_pkg::S_OUT:   if (!valid_reg || out_ready) state_next = qolm_pkg::S_IDLE;
            default:           state_next = qolm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            qolm_pkg::S_CLEAR: cmd.clear_step = 1'b1;
            qolm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = accept;
            end
            qolm_pkg::S_READ:  cmd.read = 1'b1;
            qolm_pkg::S_WRITE: cmd.write = 1'b1;
            qolm_pkg::S_EPOCH: cmd.epoch_step = 1'b1;
            qolm_pkg::S_OUT:   cmd.emit = !valid_reg || out_ready;
            default:           cmd = '0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (out_valid && out_ready) valid_next = 1'b0;
        if (cmd.emit) valid_next = 1'b1;
    end
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qolm_pkg::S_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    `ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
    `ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid)
    `ASSERT_NEXT(a_write_follows_read, clk, rst_n, cmd.read, cmd.write)
endmodule
`default_nettype wire

/* verif/queue_occupancy_latency_monitor_tb.sv */
// testbench for the queue occupancy latency monitor: random and directed queue events
// checked against a behavioral model of the counters, histograms and tag store
// depends on qolm_pkg and queue_occupancy_latency_monitor
`timescale 1ns / 1ps
module queue_occupancy_latency_monitor_tb;

    localparam int MAXLEN = 64;
    localparam int NTAGS = 256;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CMAX = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    qolm_pkg::in_item_t in_item;
    logic out_valid;
    logic out_ready;
    qolm_pkg::out_item_t out_item;

    queue_occupancy_latency_monitor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    // monitor model state
    logic [6:0] q_len, q_peak;
    logic [47:0] last_change, epoch_start;
    logic [47:0] arrival [NTAGS];
    logic present [NTAGS];
    logic [47:0] run_time [MAXLEN+1];
    logic [31:0] run_ent [MAXLEN+1];
    logic [47:0] ep_time [MAXLEN+1];
    logic [31:0] ep_ent [MAXLEN+1];
    logic [31:0] req_cnt, dep_cnt, ep_req, ep_dep;
    logic [63:0] wait_total, ep_wait_total;
    logic [47:0] wait_max;

    qolm_pkg::out_item_t expected_results [$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned beats_sent = 0;
    longint unsigned cycles = 0;
    logic [47:0] clock_ns = 0;
    bit hold_off = 0;
    bit stall_enable = 1;
    logic [7:0] live_tags [$];

    function automatic logic [47:0] add_time(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TMAX : s[47:0];
    endfunction

    function automatic logic [31:0] inc_count(logic [31:0] a);
        return (a == CMAX) ? CMAX : a + 32'd1;
    endfunction

    function automatic logic [63:0] add_wait(logic [63:0] a, logic [47:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [47:0] diff_time(logic [47:0] later, logic [47:0] earlier);
        return (later >= earlier) ? later - earlier : 48'd0;
    endfunction

    task automatic model_clear();
        q_len = 0; q_peak = 0; last_change = 0; epoch_start = 0;
        req_cnt = 0; dep_cnt = 0; ep_req = 0; ep_dep = 0;
        wait_total = 0; ep_wait_total = 0; wait_max = 0;
        for (int i = 0; i < NTAGS; i++) begin
            present[i] = 0;
            arrival[i] = 0;
        end
        for (int i = 0; i <= MAXLEN; i++) begin
            run_time[i] = 0; run_ent[i] = 0; ep_time[i] = 0; ep_ent[i] = 0;
        end
    endtask

    task automatic move_length(logic [6:0] new_len, logic [47:0] now);
        logic [47:0] dt;
        dt = diff_time(now, last_change);
        run_time[q_len] = add_time(run_time[q_len], dt);
        ep_time[q_len] = add_time(ep_time[q_len], dt);
        last_change = now;
        q_len = new_len;
        if (q_len > q_peak)
            q_peak = q_len;
        run_ent[q_len] = inc_count(run_ent[q_len]);
        ep_ent[q_len] = inc_count(ep_ent[q_len]);
    endtask

    task automatic predict_monitor(qolm_pkg::in_item_t it);
        qolm_pkg::out_item_t r;
        logic [47:0] wt, running;
        qolm_pkg::action_t act;
        wt = 0;
        r = '0;
        act = qolm_pkg::action_t'(it.action);
        case (act)
            qolm_pkg::ACT_ENQ:
                if (q_len >= MAXLEN)
                    r.status = qolm_pkg::ST_FULL;
                else
                begin
                    arrival[it.tag] = it.now;
                    present[it.tag] = 1;
                    req_cnt = inc_count(req_cnt);
                    ep_req = inc_count(ep_req);
                    move_length(q_len + 7'd1, it.now);
                end
            qolm_pkg::ACT_DEQ:
                if (q_len == 0)
                    r.status = qolm_pkg::ST_EMPTY;
                else if (!present[it.tag])
                    r.status = qolm_pkg::ST_UNKNOWN;
                else
                begin
                    present[it.tag] = 0;
                    wt = diff_time(it.now, arrival[it.tag]);
                    dep_cnt = inc_count(dep_cnt);
                    ep_dep = inc_count(ep_dep);
                    wait_total = add_wait(wait_total, wt);
                    ep_wait_total = add_wait(ep_wait_total, wt);
                    if (wt > wait_max)
                        wait_max = wt;
                    move_length(q_len - 7'd1, it.now);
                end
            qolm_pkg::ACT_EPOCH_CLR:
            begin
                ep_req = 0; ep_dep = 0; ep_wait_total = 0; epoch_start = it.now;
                for (int i = 0; i <= MAXLEN; i++) begin
                    ep_time[i] = 0;
                    ep_ent[i] = 0;
                end
            end
            qolm_pkg::ACT_NONE: ;
            default:
                if (it.bin <= MAXLEN)
                begin
                    running = (it.bin == q_len) ? diff_time(it.now, last_change) : 48'd0;
                    case (act)
                        qolm_pkg::ACT_RUN_TIME:
                            r.bin_value = add_time(run_time[it.bin], running);
                        qolm_pkg::ACT_RUN_ENT: r.bin_value = {16'd0, run_ent[it.bin]};
                        qolm_pkg::ACT_EP_TIME:
                            r.bin_value = add_time(ep_time[it.bin], running);
                        default: r.bin_value = {16'd0, ep_ent[it.bin]};
                    endcase
                end
        endcase
        r.queue_length = q_len;
        r.max_queue_length = q_peak;
        r.wait_time = wt;
        r.max_wait_time = wait_max;
        r.total_requests = req_cnt;
        r.total_departures = dep_cnt;
        r.total_wait = wait_total;
        r.epoch_requests = ep_req;
        r.epoch_departures = ep_dep;
        r.epoch_wait = ep_wait_total;
        expected_results.insert(expected_results.size(), r);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one beat: hold until accepted, then predict; valid is dropped only before a gap
    task automatic send_beat(qolm_pkg::action_t act, logic [7:0] tag, logic [47:0] now,
                             logic [6:0] bin);
        qolm_pkg::in_item_t it;
        int gap;
        it.action = act; it.tag = tag; it.now = now; it.bin = bin;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_monitor(it);
        beats_sent++;
        @(negedge clk);
    endtask

    // time advances, occasionally by a lot
    function automatic logic [47:0] tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ns = clock_ns + {$urandom(), 16'd0};
        else
            clock_ns = clock_ns + $urandom_range(0, 200);
        return clock_ns;
    endfunction

    task automatic do_enqueue();
        logic [7:0] t;
        t = 8'($urandom_range(0, 255));
        if (q_len < MAXLEN)
        begin
            live_tags.insert(live_tags.size(), t);
        end
        send_beat(qolm_pkg::ACT_ENQ, t, tick(), 7'($urandom_range(0, 127)));
    endtask

    task automatic do_dequeue();
        logic [7:0] t;
        int k;
        if (live_tags.size() > 0 && $urandom_range(0, 9) != 0)
        begin
            k = $urandom_range(0, live_tags.size() - 1);
            t = live_tags[k];
            live_tags.delete(k);
        end
        else
            t = 8'($urandom_range(0, 255));
        send_beat(qolm_pkg::ACT_DEQ, t, tick(), 7'($urandom_range(0, 127)));
    endtask

    task automatic do_read();
        qolm_pkg::action_t act;
        logic [6:0] b;
        act = qolm_pkg::action_t'($urandom_range(qolm_pkg::ACT_EPOCH_CLR,
                                                 qolm_pkg::ACT_NONE));
        if (act == qolm_pkg::ACT_EPOCH_CLR && $urandom_range(0, 3) != 0)
            act = qolm_pkg::ACT_RUN_TIME;
        b = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, q_len + 1));
        send_beat(act, 8'($urandom_range(0, 255)), tick(), b);
    endtask

    task automatic test_directed();
        send_beat(qolm_pkg::ACT_DEQ, 8'd0, 48'd0, 7'd0);            // empty queue
        send_beat(qolm_pkg::ACT_ENQ, 8'hFF, 48'd10, 7'h7F);
        send_beat(qolm_pkg::ACT_DEQ, 8'h00, 48'd20, 7'd0);          // unknown tag
        send_beat(qolm_pkg::ACT_ENQ, 8'hFF, 48'd30, 7'd0);          // tag already present
        send_beat(qolm_pkg::ACT_RUN_TIME, 8'd0, 48'd35, 7'd2);
        send_beat(qolm_pkg::ACT_RUN_TIME, 8'd0, 48'd40, 7'd65);     // bin beyond range
        send_beat(qolm_pkg::ACT_RUN_ENT, 8'd0, 48'd40, 7'd1);
        send_beat(qolm_pkg::ACT_EPOCH_CLR, 8'd0, 48'd45, 7'd0);
        send_beat(qolm_pkg::ACT_EP_TIME, 8'd0, 48'd50, 7'd2);
        send_beat(qolm_pkg::ACT_EP_ENT, 8'd0, 48'd50, 7'd2);
        send_beat(qolm_pkg::ACT_NONE, 8'hAA, TMAX, 7'h55);
        send_beat(qolm_pkg::ACT_DEQ, 8'hFF, 48'd20, 7'd0);          // time going backwards
        send_beat(qolm_pkg::ACT_DEQ, 8'hFF, TMAX, 7'd0);            // tag already gone
        send_beat(qolm_pkg::ACT_ENQ, 8'h01, 48'd0, 7'd0);
        send_beat(qolm_pkg::ACT_DEQ, 8'h01, TMAX, 7'd64);           // largest wait
        send_beat(qolm_pkg::ACT_RUN_TIME, 8'd0, TMAX, 7'd0);
        send_beat(qolm_pkg::ACT_RUN_TIME, 8'd0, 48'd0, 7'd64);
        clock_ns = TMAX - 48'd5000;
        send_beat(qolm_pkg::ACT_RUN_TIME, 8'd0, clock_ns, 7'd0);    // bin 0 read with time near its maximum
        clock_ns = 0;                                               // backwards from here on
    endtask

    task automatic test_fill_and_stall();
        hold_off = 1;
        for (int i = 0; i < 70; i++)
            send_beat(qolm_pkg::ACT_ENQ, i[7:0], tick(), 7'd0);     // last ones hit full
        live_tags.delete();
        for (int i = 0; i < 64; i++)
            live_tags.insert(live_tags.size(), i[7:0]);
        send_beat(qolm_pkg::ACT_RUN_ENT, 8'd0, tick(), 7'd64);
        for (int i = 0; i < 64; i++)
            do_dequeue();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i % 400 == 200)
                stall_enable = 0;
            if (i % 400 == 0)
                stall_enable = 1;
            r = $urandom_range(0, 99);
            if (r < 45)
                do_enqueue();
            else if (r < 85)
                do_dequeue();
            else
                do_read();
        end
    endtask

    // result checker
    always @(posedge clk) begin
        qolm_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_item.queue_length !== e.queue_length) begin
                    $error("queue_length exp %0d got %0d", e.queue_length, out_item.queue_length);
                    errors++;
                end
                if (out_item.max_queue_length !== e.max_queue_length) begin
                    $error("max_queue_length exp %0d got %0d",
                           e.max_queue_length, out_item.max_queue_length);
                    errors++;
                end
                if (out_item.wait_time !== e.wait_time) begin
                    $error("wait_time exp %0d got %0d", e.wait_time, out_item.wait_time);
                    errors++;
                end
                if (out_item.max_wait_time !== e.max_wait_time) begin
                    $error("max_wait_time exp %0d got %0d",
                           e.max_wait_time, out_item.max_wait_time);
                    errors++;
                end
                if (out_item.total_requests !== e.total_requests) begin
                    $error("total_requests exp %0d got %0d",
                           e.total_requests, out_item.total_requests);
                    errors++;
                end
                if (out_item.total_departures !== e.total_departures) begin
                    $error("total_departures exp %0d got %0d",
                           e.total_departures, out_item.total_departures);
                    errors++;
                end
                if (out_item.total_wait !== e.total_wait) begin
                    $error("total_wait exp %0d got %0d", e.total_wait, out_item.total_wait);
                    errors++;
                end
                if (out_item.epoch_requests !== e.epoch_requests) begin
                    $error("epoch_requests exp %0d got %0d",
                           e.epoch_requests, out_item.epoch_requests);
                    errors++;
                end
                if (out_item.epoch_departures !== e.epoch_departures) begin
                    $error("epoch_departures exp %0d got %0d",
                           e.epoch_departures, out_item.epoch_departures);
                    errors++;
                end
                if (out_item.epoch_wait !== e.epoch_wait) begin
                    $error("epoch_wait exp %0d got %0d", e.epoch_wait, out_item.epoch_wait);
                    errors++;
                end
                if (out_item.bin_value !== e.bin_value) begin
                    $error("bin_value exp %0d got %0d", e.bin_value, out_item.bin_value);
                    errors++;
                end
                if (out_item.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, out_item.status);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            if (!stall_enable || $urandom_range(0, 2) != 0)
                out_ready <= 1;
            else
            begin
                out_ready <= 0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        int waited;
        in_valid = 0;
        in_item = '0;
        rst_n = 0;
        model_clear();
        repeat (6) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_fill_and_stall();
        test_random(1500);
        in_valid <= 0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        $display("sent %0d beats, checked %0d results, including fill to capacity",
                 beats_sent, results_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
